// ----- rtl/trb_pkg.sv -----
// trb_pkg: shared types and constants of the timestamp reorder buffer.
// Used by every module in rtl/ and by the port checker; depends on nothing.
`default_nettype none

package trb_pkg;

    // Slot capacity: default and upper bound of the legal range
    localparam int CAPACITY_DEF = 8;
    localparam int CAPACITY_MAX = 64;
    localparam int IDX_MAX_W    = $clog2(CAPACITY_MAX);

    // Field widths
    localparam int TS_W   = 32;
    localparam int LEN_W  = 12;
    localparam int REF_W  = 16;
    localparam int SID_W  = 16;
    localparam int HOLD_W = 3;

    // Packed stream widths, rounded up to whole bytes
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 80;

    // Configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLD_COUNT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_STREAM_ID  = 1'b1;

    // Reset values and limits
    localparam logic [HOLD_W-1:0] HOLD_RESET   = 3'd3;
    localparam logic [SID_W-1:0]  STREAM_RESET = 16'd0;
    localparam logic [LEN_W-1:0]  MAX_LENGTH   = 12'd2560;

    // One held packet descriptor
    typedef struct packed {
        logic [REF_W-1:0] pref;
        logic [LEN_W-1:0] plen;
        logic [TS_W-1:0]  ts;
    } slot_t;

    // Outcome of one pass over the slots
    typedef struct packed {
        logic                 dup;
        logic                 have_best;
        logic [IDX_MAX_W-1:0] best_idx;
        slot_t                best;
        logic                 have_free;
        logic [IDX_MAX_W-1:0] free_idx;
    } scan_res_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/trb_slot_mem.sv -----
// trb_slot_mem: descriptor store, one write port and one registered read port.
// Depends on trb_pkg for the slot_t type.
`default_nettype none

module trb_slot_mem #(
    parameter int CAPACITY = trb_pkg::CAPACITY_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic [$clog2(CAPACITY)-1:0] wr_addr,
    input  wire trb_pkg::slot_t              wr_data,
    input  wire logic [$clog2(CAPACITY)-1:0] rd_addr,
    output trb_pkg::slot_t                   rd_data_reg
);

    trb_pkg::slot_t mem [CAPACITY];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/trb_scan_unit.sv -----
// trb_scan_unit: shared compare unit, one slot per beat of the scan.
// Tracks duplicate hit, smallest held timestamp and first free slot.
// Depends on trb_pkg.
`default_nettype none

module trb_scan_unit #(
    parameter int CAPACITY = trb_pkg::CAPACITY_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        clear,
    input  wire logic                        step,
    input  wire logic [$clog2(CAPACITY)-1:0] step_idx,
    input  wire logic                        step_valid,
    input  wire trb_pkg::slot_t              step_slot,
    input  wire logic [trb_pkg::TS_W-1:0]    key_ts,
    output trb_pkg::scan_res_t               res
);

    trb_pkg::scan_res_t res_reg, res_next;
    logic               hit_eq;
    logic               hit_lt;

    // the one compare pair, shared by every slot in turn
    assign hit_eq = step_valid && (step_slot.ts == key_ts);
    assign hit_lt = step_valid && (!res_reg.have_best || (step_slot.ts < res_reg.best.ts));

    always_comb begin
        res_next = res_reg;
        if (clear) begin
            res_next.dup       = 1'b0;
            res_next.have_best = 1'b0;
            res_next.have_free = 1'b0;
        end else if (step) begin
            if (hit_eq) begin
                res_next.dup = 1'b1;
            end
            if (hit_lt) begin
                res_next.have_best = 1'b1;
                res_next.best_idx  = trb_pkg::IDX_MAX_W'(step_idx);
                res_next.best      = step_slot;
            end
            // first empty slot in index order
            if (!step_valid && !res_reg.have_free) begin
                res_next.have_free = 1'b1;
                res_next.free_idx  = trb_pkg::IDX_MAX_W'(step_idx);
            end
        end
    end

    // flags are reset, the payload part of the result needs none
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg.dup       <= 1'b0;
            res_reg.have_best <= 1'b0;
            res_reg.have_free <= 1'b0;
        end else begin
            res_reg.dup       <= res_next.dup;
            res_reg.have_best <= res_next.have_best;
            res_reg.have_free <= res_next.have_free;
        end
        res_reg.best_idx <= res_next.best_idx;
        res_reg.best     <= res_next.best;
        res_reg.free_idx <= res_next.free_idx;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ----- rtl/timestamp_reorder_buffer.sv -----
// timestamp_reorder_buffer: top level, sequencer, valid marks and output register.
// Instantiates trb_slot_mem and trb_scan_unit; depends on trb_pkg.
//
// Use: packet descriptors arrive on the s_ stream (one beat per packet) and
// released frames leave on the m_ stream, smallest timestamp first. A packet
// whose timestamp is already held is dropped without any output beat. Once
// hold_count packets (limited to CAPACITY-1) are held, each new packet
// releases exactly one frame: the smallest held one, or the new packet
// itself when its timestamp is below all held ones.
// Timing: after an accepted beat the block scans every slot through one
// registered memory read port and one compare unit, one slot per cycle, and
// keeps s_tready low through the scan, the decision and, when the packet
// releases a frame, the emit step, which loads the output register that
// drives m_tvalid. A new packet is taken only once the last one has been
// stored, dropped or released.
// Stalls: the output register holds a frame until m_tready; a new packet is
// accepted meanwhile, and its own release waits until the register is free.
// Reset (aresetn low, synchronous) clears every valid mark, the held count,
// the output valid flag and sets the configuration to hold_count 3, stream_id 0.
// Configuration writes (cfg_wr_en) take effect at once and are meant for an
// idle block.
`default_nettype none

module timestamp_reorder_buffer #(
    parameter int CAPACITY = trb_pkg::CAPACITY_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration write port
    input  wire logic                            cfg_wr_en,
    input  wire logic [trb_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [trb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // rtp_timestamp[31:0], payload_length[43:32], payload_ref[59:44], zero pad
    input  wire logic [trb_pkg::S_DATA_W-1:0]    s_tdata,
    // output stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // frame_stream_id[15:0], frame_timestamp[47:16], frame_length[59:48],
    // frame_ref[75:60], zero pad
    output logic [trb_pkg::M_DATA_W-1:0]         m_tdata
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > trb_pkg::HOLD_W) ? CW : trb_pkg::HOLD_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
    localparam logic [LW-1:0] HOLD_MAX = LW'(CAPACITY - 1);

    // configuration
    logic [trb_pkg::HOLD_W-1:0] hold_reg, hold_next;
    logic [trb_pkg::SID_W-1:0]  sid_reg, sid_next;

    // control state
    trb_pkg::state_t     state_reg, state_next;
    logic [IW-1:0]       addr_reg, addr_next;
    logic                step_reg, step_next;
    logic [IW-1:0]       step_idx_reg;
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [CW-1:0]       held_reg, held_next;
    logic                m_valid_reg, m_valid_next;

    // payload registers
    trb_pkg::slot_t                in_reg, in_next;
    logic [trb_pkg::M_DATA_W-1:0]  m_data_reg, m_data_next;

    // datapath wiring
    trb_pkg::slot_t     rd_slot;
    trb_pkg::slot_t     wr_slot;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    trb_pkg::scan_res_t res;
    logic               scan_clear;
    logic [LW-1:0]      hold_ext;
    logic [LW-1:0]      limit;
    logic               room;
    logic               new_is_min;
    logic               out_free;
    logic [trb_pkg::LEN_W-1:0] s_len;
    trb_pkg::slot_t     emit_slot;

    trb_slot_mem #(
        .CAPACITY (CAPACITY)
    ) u_mem (
        .aclk        (aclk),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_slot),
        .rd_addr     (addr_reg),
        .rd_data_reg (rd_slot)
    );

    trb_scan_unit #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (scan_clear),
        .step       (step_reg),
        .step_idx   (step_idx_reg),
        .step_valid (valid_reg[step_idx_reg]),
        .step_slot  (rd_slot),
        .key_ts     (in_reg.ts),
        .res        (res)
    );

    // effective hold, never above CAPACITY-1
    assign hold_ext   = LW'(hold_reg);
    assign limit      = (hold_ext > HOLD_MAX) ? HOLD_MAX : hold_ext;
    assign room       = LW'(held_reg) < limit;
    assign new_is_min = !res.have_best || (in_reg.ts < res.best.ts);
    assign out_free   = !m_valid_reg || m_tready;

    // input length saturates at the largest payload
    assign s_len = (s_tdata[43:32] > trb_pkg::MAX_LENGTH) ? trb_pkg::MAX_LENGTH
                                                          : s_tdata[43:32];

    assign emit_slot = new_is_min ? in_reg : res.best;
    assign wr_slot   = in_reg;

    // configuration writes
    always_comb begin
        hold_next = hold_reg;
        sid_next  = sid_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                trb_pkg::REG_HOLD_COUNT: hold_next = cfg_wdata[trb_pkg::HOLD_W-1:0];
                trb_pkg::REG_STREAM_ID:  sid_next  = cfg_wdata[trb_pkg::SID_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        step_next    = 1'b0;
        valid_next   = valid_reg;
        held_next    = held_reg;
        m_valid_next = m_valid_reg;
        in_next      = in_reg;
        m_data_next  = m_data_reg;
        scan_clear   = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = res.free_idx[IW-1:0];
        s_tready     = 1'b0;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            trb_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    in_next.ts   = s_tdata[31:0];
                    in_next.plen = s_len;
                    in_next.pref = s_tdata[59:44];
                    addr_next    = '0;
                    scan_clear   = 1'b1;
                    state_next   = trb_pkg::ST_SCAN;
                end
            end
            trb_pkg::ST_SCAN: begin
                // issue one read per beat; compare follows on the registered read data
                step_next = 1'b1;
                if (addr_reg == LAST_IDX) begin
                    state_next = trb_pkg::ST_DRAIN;
                end else begin
                    addr_next = addr_reg + IW'(1);
                end
            end
            trb_pkg::ST_DRAIN: begin
                state_next = trb_pkg::ST_DECIDE;
            end
            trb_pkg::ST_DECIDE: begin
                if (res.dup) begin
                    state_next = trb_pkg::ST_IDLE;
                end else if (room) begin
                    wr_en                 = 1'b1;
                    wr_addr               = res.free_idx[IW-1:0];
                    valid_next[wr_addr]   = 1'b1;
                    held_next             = held_reg + CW'(1);
                    state_next            = trb_pkg::ST_IDLE;
                end else begin
                    state_next = trb_pkg::ST_EMIT;
                end
            end
            trb_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'd0, emit_slot.pref, emit_slot.plen,
                                    emit_slot.ts, sid_reg};
                    // the new packet takes the released slot
                    if (!new_is_min) begin
                        wr_en   = 1'b1;
                        wr_addr = res.best_idx[IW-1:0];
                    end
                    state_next = trb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = trb_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= trb_pkg::ST_IDLE;
            addr_reg    <= '0;
            step_reg    <= 1'b0;
            valid_reg   <= '0;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
            hold_reg    <= trb_pkg::HOLD_RESET;
            sid_reg     <= trb_pkg::STREAM_RESET;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            step_reg    <= step_next;
            valid_reg   <= valid_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
            hold_reg    <= hold_next;
            sid_reg     <= sid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        step_idx_reg <= addr_reg;
        in_reg       <= in_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ----- rtl/trb_port_checker.sv -----
// trb_port_checker: assertions on the top-level ports of the reorder buffer,
// bound to timestamp_reorder_buffer. Depends on trb_pkg.
`default_nettype none

module trb_port_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [trb_pkg::M_DATA_W-1:0] m_tdata
);

    // a stalled output beat stays offered
    a_m_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // a stalled output beat keeps its payload
    a_m_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // the block is busy scanning right after taking a packet
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("s_tready high in the cycle after an accepted beat");

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

endmodule

bind timestamp_reorder_buffer trb_port_checker u_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
